// ===== rtl/ets_pkg.sv =====
// ets_pkg: shared widths and constants for the exponential series unit
// no dependencies; imported by ets_term_unit and exp_taylor_series_unit
`default_nettype none

package ets_pkg;

  // argument format, signed q5.26
  localparam int unsigned XW      = 31;
  localparam int unsigned XMAG_W  = 30;
  localparam int unsigned X_FRAC  = 26;
  localparam logic [31:0] X_LIMIT = 32'h2000_0000;

  // threshold register, q.40
  localparam int unsigned          THR_W     = 41;
  localparam int unsigned          OUT_FRAC  = 40;
  localparam logic [THR_W-1:0]     THR_RESET = 41'd10995;

  // result format
  localparam int unsigned          RES_W   = 52;
  localparam int unsigned          TERMS_W = 7;
  localparam logic [RES_W-1:0]     RES_MAX = {RES_W{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/ets_term_unit.sv =====
// ets_term_unit: shared multi-cycle unit computing floor(floor(mag * x / 2^26) / k)
// one multiplier over two partial products, then an 8-bit-per-cycle divider
// depends on ets_pkg
`default_nettype none

module ets_term_unit
  import ets_pkg::*;
#(
  parameter int unsigned MAG_W = 49,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [MAG_W-1:0]  mag_i,
  input  wire logic [XMAG_W-1:0] xmag_i,
  input  wire logic [CNT_W-1:0]  k_i,
  output logic                   done_o,
  output logic [MAG_W-1:0]       quo_o
);

  localparam int unsigned HALF      = (MAG_W + 1) / 2;
  localparam int unsigned PP_W      = HALF + XMAG_W;
  localparam int unsigned PROD_W    = 2 * HALF + XMAG_W;
  localparam int unsigned DIV_W     = MAG_W + 3;
  localparam int unsigned DIV_STEPS = (DIV_W + 7) / 8;
  localparam int unsigned PAD_W     = DIV_STEPS * 8;
  localparam int unsigned SC_W      = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    U_IDLE,
    U_LO,
    U_HI,
    U_ADD,
    U_DIV
  } unit_state_e;

  unit_state_e       state_q, state_d;
  logic [MAG_W-1:0]  a_q, a_d;
  logic [XMAG_W-1:0] b_q, b_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [PP_W-1:0]   pp_q, pp_d;
  logic [PP_W-1:0]   acc_q, acc_d;
  logic [PAD_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SC_W-1:0]   sc_q, sc_d;
  logic              done_q, done_d;

  logic [HALF-1:0]   mul_a;
  logic [PP_W-1:0]   mul_p;
  logic [PROD_W-1:0] full_prod;
  logic [CNT_W:0]    rem_t;
  logic [CNT_W-1:0]  rem_w;
  logic [7:0]        qbits;

  assign mul_a = (state_q == U_LO) ? a_q[HALF-1:0] : HALF'(a_q[MAG_W-1:HALF]);
  assign mul_p = PP_W'(mul_a) * PP_W'(b_q);
  assign full_prod = PROD_W'(acc_q) + (PROD_W'(pp_q) << HALF);

  // eight restoring steps on the top byte of the dividend
  always_comb begin
    rem_w = rem_q;
    rem_t = '0;
    qbits = '0;
    for (int i = 0; i < 8; i++) begin
      rem_t = {rem_w, n_q[PAD_W-1-i]};
      if (rem_t >= {1'b0, k_q}) begin
        rem_t    = rem_t - {1'b0, k_q};
        qbits[7-i] = 1'b1;
      end
      rem_w = rem_t[CNT_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    pp_d    = pp_q;
    acc_d   = acc_q;
    n_d     = n_q;
    rem_d   = rem_q;
    sc_d    = sc_q;
    done_d  = 1'b0;
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          a_d     = mag_i;
          b_d     = xmag_i;
          k_d     = k_i;
          state_d = U_LO;
        end
      end
      U_LO: begin
        pp_d    = mul_p;
        state_d = U_HI;
      end
      U_HI: begin
        acc_d   = pp_q;
        pp_d    = mul_p;
        state_d = U_ADD;
      end
      U_ADD: begin
        n_d     = PAD_W'(full_prod >> X_FRAC);
        rem_d   = '0;
        sc_d    = SC_W'(DIV_STEPS - 1);
        state_d = U_DIV;
      end
      U_DIV: begin
        n_d   = {n_q[PAD_W-9:0], qbits};
        rem_d = rem_w;
        sc_d  = sc_q - 1'b1;
        if (sc_q == '0) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    pp_q  <= pp_d;
    acc_q <= acc_d;
    n_q   <= n_d;
    rem_q <= rem_d;
    sc_q  <= sc_d;
  end

  assign done_o = done_q;
  assign quo_o  = n_q[MAG_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/exp_taylor_series_unit.sv =====
// exp_taylor_series_unit: e^x by taylor series on a shared term unit
// depends on ets_pkg and ets_term_unit
//
// usage
//   input channel: x_value_i (signed q5.26) with in_valid_i / in_stall_o; a beat
//   is taken when valid is high and stall is low. stall is high from the
//   accepted beat until the series is summed and the result is loaded.
//   output channel: exp_result_o (q12.40), terms_used_o, limit_hit_o with
//   out_valid_o / out_stall_i. the result stays in an output register until
//   taken, so a new argument can be accepted while a result waits.
//   config: cfg_we_i writes cfg_wdata_i into the threshold register; write
//   only while no argument is being worked on.
//   term loop: between the accepted beat and out_valid_o, each of up to MAX_TERMS
//   terms runs through the term unit's two-pass multiply and its byte-per-cycle
//   divide by the term index.
//   input pacing: one argument at a time; the next beat can be taken the cycle after
//   the result is loaded.
//   reset: threshold returns to about 1e-8, no result pending, ready for input.
//   receiver stall: a finished sum waits for the output register to free up.
`default_nettype none

module exp_taylor_series_unit
  import ets_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 64,
  parameter int unsigned FRAC_BITS = 40
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [THR_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [XW-1:0] x_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [RES_W-1:0]          exp_result_o,
  output logic [TERMS_W-1:0]        terms_used_o,
  output logic                      limit_hit_o
);

  localparam int unsigned MAG_W  = FRAC_BITS + 9;
  localparam int unsigned SUM_W  = FRAC_BITS + 13;
  localparam int unsigned CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int unsigned SH_UP  = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int unsigned SH_DN  = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam int unsigned CMP_A  = THR_W + SH_UP;
  localparam int unsigned CMP_W  = (CMP_A > MAG_W) ? CMP_A : MAG_W;
  localparam int unsigned RW_A   = (SUM_W > RES_W) ? SUM_W : RES_W;
  localparam int unsigned RW     = RW_A + SH_DN;

  localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;
  localparam logic [CMP_W:0]   RND_C   = (CMP_W + 1)'((64'd1 << SH_DN) - 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT,
    S_FINISH
  } seq_state_e;

  seq_state_e          state_q, state_d;
  logic [THR_W-1:0]    thr_q, thr_d;
  logic                xneg_q, xneg_d;
  logic [XMAG_W-1:0]   xmag_q, xmag_d;
  logic [MAG_W-1:0]    tmag_q, tmag_d;
  logic                tneg_q, tneg_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [RES_W-1:0]    res_q, res_d;
  logic [TERMS_W-1:0]  terms_q, terms_d;
  logic                limit_q, limit_d;

  logic                unit_start;
  logic                unit_done;
  logic [MAG_W-1:0]    unit_quo;
  logic [CNT_W-1:0]    cnt_inc;

  logic [CMP_W:0]      thr_wide;
  logic [CMP_W:0]      thr_cmp;
  logic                below;
  logic [31:0]         raw_ext;
  logic [31:0]         neg_mag;
  logic [31:0]         xm32;
  logic                tneg_nx;
  logic [RW-1:0]       sum_u;
  logic [RW-1:0]       sum_al;
  logic [RES_W-1:0]    res_fmt;
  logic                out_free;

  assign cnt_inc = cnt_q + 1'b1;

  ets_term_unit #(
    .MAG_W (MAG_W),
    .CNT_W (CNT_W)
  ) u_term (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .mag_i   (tmag_q),
    .xmag_i  (xmag_q),
    .k_i     (cnt_inc),
    .done_o  (unit_done),
    .quo_o   (unit_quo)
  );

  // threshold rescaled to the term format
  always_comb begin
    thr_wide = (CMP_W + 1)'(thr_q);
    if (FRAC_BITS >= OUT_FRAC) begin
      thr_cmp = thr_wide << SH_UP;
    end else begin
      thr_cmp = (thr_wide + RND_C) >> SH_DN;
    end
  end
  assign below = (CMP_W + 1)'(tmag_q) < thr_cmp;

  // argument sign and clamped magnitude
  assign raw_ext = {1'b0, x_value_i};
  assign neg_mag = 32'h8000_0000 - raw_ext;
  always_comb begin
    xm32 = x_value_i[XW-1] ? neg_mag : raw_ext;
    if (xm32 > X_LIMIT) begin
      xm32 = X_LIMIT;
    end
  end

  assign tneg_nx = tneg_q ^ xneg_q;

  // final sum to q.40, clamped to the result range
  assign sum_u  = RW'(sum_q[SUM_W-2:0]);
  assign sum_al = sum_u >> SH_UP;
  always_comb begin
    if (sum_q[SUM_W-1]) begin
      res_fmt = '0;
    end else if (sum_al > (RW'(RES_MAX) >> SH_DN)) begin
      res_fmt = RES_MAX;
    end else begin
      res_fmt = RES_W'(sum_al << SH_DN);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    thr_d       = thr_q;
    xneg_d      = xneg_q;
    xmag_d      = xmag_q;
    tmag_d      = tmag_q;
    tneg_d      = tneg_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    terms_d     = terms_q;
    limit_d     = limit_q;
    unit_start  = 1'b0;
    if (cfg_we_i) begin
      thr_d = cfg_wdata_i;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          xneg_d  = x_value_i[XW-1];
          xmag_d  = XMAG_W'(xm32);
          tmag_d  = ONE_MAG;
          tneg_d  = 1'b0;
          sum_d   = SUM_W'(ONE_MAG);
          cnt_d   = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (below || cnt_q == CNT_MAX) begin
          state_d = S_FINISH;
        end else begin
          unit_start = 1'b1;
          cnt_d      = cnt_inc;
          state_d    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (unit_done) begin
          tmag_d  = unit_quo;
          tneg_d  = tneg_nx;
          sum_d   = tneg_nx ? sum_q - SUM_W'(unit_quo) : sum_q + SUM_W'(unit_quo);
          state_d = S_CHECK;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = res_fmt;
          terms_d     = TERMS_W'(cnt_q);
          limit_d     = !below;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      thr_q       <= thr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xneg_q  <= xneg_d;
    xmag_q  <= xmag_d;
    tmag_q  <= tmag_d;
    tneg_q  <= tneg_d;
    sum_q   <= sum_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    terms_q <= terms_d;
    limit_q <= limit_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign exp_result_o = res_q;
  assign terms_used_o = terms_q;
  assign limit_hit_o  = limit_q;

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> state_q == S_WAIT)
    else $error("term unit finished outside of wait state");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> cnt_q <= CNT_MAX)
    else $error("term count above limit");

  a_limit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && limit_hit_o |-> terms_used_o == TERMS_W'(MAX_TERMS))
    else $error("limit flag without full term count");

  a_start_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_start |=> state_q == S_WAIT && !unit_done)
    else $error("term unit start not followed by wait");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: self-checking bench for exp_taylor_series_unit, e^x by taylor series
// depends on ets_pkg and exp_taylor_series_unit; carries its own bit-exact model
// of the series sum and checks every result beat in order against it
`default_nettype none

module testbench;
  import ets_pkg::*;

  localparam int unsigned MAX_TERMS   = 64;
  localparam int unsigned FRAC_BITS   = 40;
  localparam int          IDLE_LIMIT  = 20000;
  localparam int          TAIL_CYCLES = 1000;
  localparam int          PRINT_CAP   = 40;

  typedef struct packed {
    logic [RES_W-1:0]   value;
    logic [TERMS_W-1:0] terms;
    logic               hit;
  } exp_beat_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [THR_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic signed [XW-1:0] x_value_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [RES_W-1:0]     exp_result_o;
  logic [TERMS_W-1:0]   terms_used_o;
  logic                 limit_hit_o;

  exp_beat_t        pending_exp_q[$];
  logic [THR_W-1:0] threshold_q = THR_RESET;
  bit               calm        = 1'b0;
  int               long_hold   = 0;
  int               fail_count  = 0;
  int               args_sent   = 0;
  int               results_seen = 0;
  int               limit_hits  = 0;
  int               thr_writes  = 0;
  int               idle_cycles = 0;

  exp_taylor_series_unit #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_value_i    (x_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .exp_result_o (exp_result_o),
    .terms_used_o (terms_used_o),
    .limit_hit_o  (limit_hit_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic exp_beat_t predict_exp(logic [XW-1:0] x, logic [THR_W-1:0] thr);
    logic [63:0]  xmag;
    logic [63:0]  tmag;
    logic [63:0]  sum;
    logic [63:0]  res;
    logic [63:0]  thr_q;
    logic [127:0] prod;
    logic         tneg;
    logic         stopped;
    int unsigned  count;
    exp_beat_t    r;
    xmag = x[XW-1] ? (64'h8000_0000 - {33'd0, x}) : {33'd0, x};
    if (xmag > {32'd0, X_LIMIT}) xmag = {32'd0, X_LIMIT};
    if (FRAC_BITS >= OUT_FRAC) thr_q = {23'd0, thr} << (FRAC_BITS - OUT_FRAC);
    else thr_q = ({23'd0, thr} + ((64'd1 << (OUT_FRAC - FRAC_BITS)) - 64'd1))
                 >> (OUT_FRAC - FRAC_BITS);
    tmag    = 64'd1 << FRAC_BITS;
    sum     = tmag;
    tneg    = 1'b0;
    count   = 0;
    stopped = tmag < thr_q;
    while (!stopped && count < MAX_TERMS) begin
      count++;
      prod = {64'd0, tmag} * {64'd0, xmag};
      prod = prod >> X_FRAC;
      tmag = prod[63:0] / 64'(count);
      tneg = tneg ^ x[XW-1];
      sum  = tneg ? sum - tmag : sum + tmag;
      stopped = tmag < thr_q;
    end
    if (sum[63]) res = '0;
    else if (FRAC_BITS >= OUT_FRAC) res = sum >> (FRAC_BITS - OUT_FRAC);
    else if (sum > ({12'd0, RES_MAX} >> (OUT_FRAC - FRAC_BITS))) res = {12'd0, RES_MAX};
    else res = sum << (OUT_FRAC - FRAC_BITS);
    if (res > {12'd0, RES_MAX}) res = {12'd0, RES_MAX};
    r.value = res[RES_W-1:0];
    r.terms = count[TERMS_W-1:0];
    r.hit   = !stopped;
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 96) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic logic signed [XW-1:0] rand_x();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 60) v = int'($urandom_range(0, 1073741824)) - 536870912;
    else if (r < 75) v = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    else if (r < 90) v = int'($urandom());
    else begin
      case ($urandom_range(0, 5))
        0: v = 1 << 29;
        1: v = -(1 << 29);
        2: v = (1 << 30) - 1;
        3: v = -(1 << 30);
        4: v = 0;
        default: v = -1;
      endcase
    end
    return v[XW-1:0];
  endfunction

  function automatic logic [THR_W-1:0] rand_thr();
    int unsigned r;
    logic [63:0] w;
    r = $urandom_range(0, 9);
    if (r < 4) return THR_RESET;
    if (r < 8) begin
      w = {$urandom(), $urandom()};
      w = w >> $urandom_range(23, 62);
      return w[THR_W-1:0];
    end
    case ($urandom_range(0, 2))
      0: return THR_W'(1);
      1: return THR_W'(1) << 40;
      default: return {THR_W{1'b1}};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  // one argument beat, held until taken
  task automatic send_arg(input logic signed [XW-1:0] x);
    int gap;
    in_valid_i <= 1'b1;
    x_value_i  <= x;
    do @(posedge clk_i); while (in_stall_o);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_exp_q.size() != 0);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] thr);
    cfg_wdata_i <= thr;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    threshold_q = thr;
    thr_writes++;
    @(posedge clk_i);
  endtask

  // accepted argument: predict its result
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_exp_q.push_back(predict_exp(x_value_i, threshold_q));
      args_sent++;
    end
  end

  always @(posedge clk_i) begin : check_results
    exp_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (limit_hit_o) limit_hits++;
      if (pending_exp_q.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(exp_result_o), 64'd0);
      end else begin
        want = pending_exp_q.pop_front();
        if (exp_result_o !== want.value)
          report_mismatch("exp_result", 64'(exp_result_o), 64'(want.value));
        if (terms_used_o !== want.terms)
          report_mismatch("terms_used", 64'(terms_used_o), 64'(want.terms));
        if (limit_hit_o !== want.hit)
          report_mismatch("limit_hit", 64'(limit_hit_o), 64'(want.hit));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random stalls, or a long hold when asked
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk_i);
      if (long_hold != 0) begin
        n = long_hold;
        long_hold = 0;
      end else begin
        n = calm ? 0 : pick_gap();
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_basic_args();
    int args[] = '{0, 1, -1, 1 << 26, -(1 << 26), 1 << 29, -(1 << 29),
                   (1 << 29) + 1, -(1 << 29) - 1, (1 << 30) - 1, -(1 << 30),
                   32'h2AAA_AAAA, 32'h5555_5555};
    foreach (args[i]) send_arg(args[i][XW-1:0]);
    wait_drained();
  endtask

  task automatic test_threshold_extremes();
    // zero threshold: every sum runs to the term limit
    set_threshold('0);
    send_arg(XW'(0));
    send_arg(XW'(1 << 29));
    send_arg(XW'(-(1 << 29)));
    send_arg(XW'(1 << 24));
    wait_drained();
    // above 1.0: nothing past the leading one
    set_threshold({THR_W{1'b1}});
    send_arg(XW'(1 << 29));
    send_arg(XW'(-1));
    wait_drained();
    // exactly 1.0
    set_threshold(THR_W'(1) << 40);
    send_arg(XW'(1 << 26));
    send_arg(XW'(1 << 20));
    wait_drained();
    set_threshold((THR_W'(1) << 40) + THR_W'(1));
    send_arg(XW'(1 << 29));
    wait_drained();
    // smallest nonzero threshold, longest stopping sums
    set_threshold(THR_W'(1));
    send_arg(XW'(1 << 29));
    send_arg(XW'(-(1 << 29)));
    wait_drained();
    set_threshold(THR_RESET);
  endtask

  task automatic test_output_backpressure();
    calm = 1'b1;
    long_hold = 3000;
    repeat (10) send_arg(XW'(int'($urandom_range(0, 1 << 25)) - (1 << 24)));
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_random_args();
    int n;
    for (int p = 0; p < 9; p++) begin
      n = 75;
      if (p == 0) set_threshold(THR_RESET);
      else if (p == 4) begin
        set_threshold('0);
        n = 6;
      end else set_threshold(rand_thr());
      calm = (p == 2);
      repeat (n) send_arg(rand_x());
      wait_drained();
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_args();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_args();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_exp_q.size() != 0)
      report_mismatch("results never delivered", 64'(pending_exp_q.size()), 64'd0);
    $display("sent %0d arguments, checked %0d results (%0d at the term limit)",
             args_sent, results_seen, limit_hits);
    $display("%0d threshold writes incl. zero, 1.0 and all ones; long output hold once",
             thr_writes);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ets_pkg.sv
rtl/ets_term_unit.sv
rtl/exp_taylor_series_unit.sv
bench/testbench.sv
